>>> design/capacitive_touch_swipe_detector_top_assert.svh
// Assertion macros used by the checker file.
`ifndef CAPACITIVE_TOUCH_SWIPE_DETECTOR_TOP_ASSERT_SVH
`define CAPACITIVE_TOUCH_SWIPE_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication
`define CTSD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CTSD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ctsd_pkg.sv
package ctsd_pkg;

	localparam int KIND_W     = 2;
	localparam int PAD_W      = 3;
	localparam int LEVEL_W    = 16;
	localparam int NOW_W      = 32;
	localparam int DELTA_W    = 17;
	localparam int EV_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CAL    = 2'd2;

	localparam logic [EV_W-1:0] PEV_NONE    = 2'd0;
	localparam logic [EV_W-1:0] PEV_TOUCH   = 2'd1;
	localparam logic [EV_W-1:0] PEV_RELEASE = 2'd2;

	localparam logic [EV_W-1:0] SEV_NONE = 2'd0;
	localparam logic [EV_W-1:0] SEV_POS  = 2'd1;
	localparam logic [EV_W-1:0] SEV_NEG  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPMIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPMAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RESTART = 3'd5;

	localparam logic [3:0]  RST_ACTIVE  = 4'd8;
	localparam logic [15:0] RST_THRESH  = 16'd1120;
	localparam logic [2:0]  RST_TICKS   = 3'd2;
	localparam logic [15:0] RST_STEPMIN = 16'd10;
	localparam logic [15:0] RST_STEPMAX = 16'd150;
	localparam logic [15:0] RST_RESTART = 16'd500;

	// window select, also the top address bits of the window RAM
	localparam logic [1:0] WIN_SAMPLE = 2'd0;
	localparam logic [1:0] WIN_BASE   = 2'd1;
	localparam logic [1:0] WIN_SUPER  = 2'd2;

	typedef struct packed {
		logic load;
		logic clr;
		logic start_sample;
		logic start_tick;
		logic calib;
		logic wr;
		logic rd;
		logic res;
		logic next_pad;
		logic eval;
		logic sw_step;
		logic sw_end;
		logic out;
	} cmd_t;

	typedef struct packed {
		logic             clr_last;
		logic [KIND_W-1:0] kind;
		logic             pad_ok;
		logic             rd_last;
		logic [1:0]       sel;
		logic             phase_zero;
		logic             pad_last;
		logic             swipe_go;
		logic             out_free;
	} sts_t;

endpackage

>>> design/ctsd_ram.sv
module ctsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/ctsd_median.sv
module ctsd_median #(
	parameter int DEPTH = 20,
	parameter int LW    = 5,
	parameter int CW    = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          insert,
	input  logic [15:0]   din,
	input  logic [LW-1:0] mid,
	output logic [15:0]   med
);

	logic [15:0]   srt_q [DEPTH];
	logic [15:0]   nxt   [DEPTH];
	logic [CW-1:0] cnt_q;
	logic [DEPTH:0] gs;

	// insertion into a sorted row: entries above din move up one place
	always_comb begin
		gs[0] = 1'b0;
		for (int j = 0; j < DEPTH; j++) begin
			gs[j+1] = (int'(cnt_q) > j) && (srt_q[j] > din);
		end
		for (int j = 0; j < DEPTH; j++) begin
			nxt[j] = din;
			if ((int'(cnt_q) > j) && !gs[j+1]) begin
				nxt[j] = srt_q[j];
			end else if (gs[j]) begin
				nxt[j] = srt_q[(j > 0) ? j - 1 : 0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clear) begin
			cnt_q <= '0;
		end else if (insert) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (insert) begin
			for (int j = 0; j < DEPTH; j++) begin
				srt_q[j] <= nxt[j];
			end
		end
	end

	assign med = srt_q[mid];

endmodule

>>> design/ctsd_datapath.sv
module ctsd_datapath #(
	parameter int MAX_PADS     = 8,
	parameter int SAMPLE_DEPTH = 7,
	parameter int BASE_DEPTH   = 20,
	parameter int SUPER_DEPTH  = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [ctsd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ctsd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [ctsd_pkg::KIND_W-1:0]          kind,
	input  logic [ctsd_pkg::PAD_W-1:0]           pad,
	input  logic [ctsd_pkg::LEVEL_W-1:0]         level,
	input  logic [ctsd_pkg::NOW_W-1:0]           now_ms,
	input  ctsd_pkg::cmd_t                       cmd,
	output ctsd_pkg::sts_t                       sts,
	input  logic                                 m_tready,
	output logic                                 m_tvalid,
	output logic [ctsd_pkg::DELTA_W-1:0]         delta,
	output logic [ctsd_pkg::EV_W-1:0]            pad_event,
	output logic [ctsd_pkg::EV_W-1:0]            swipe_event
);

	localparam int MAXD0 = (SAMPLE_DEPTH > BASE_DEPTH) ? SAMPLE_DEPTH : BASE_DEPTH;
	localparam int MAXD  = (MAXD0 > SUPER_DEPTH) ? MAXD0 : SUPER_DEPTH;
	localparam int LW    = (MAXD > 1) ? $clog2(MAXD) : 1;
	localparam int CW    = $clog2(MAXD + 1);
	localparam int PW    = $clog2(MAX_PADS);
	localparam int NW    = $clog2(MAX_PADS + 1);
	localparam int PHW   = $clog2(BASE_DEPTH + 1);
	localparam int AW    = 2 + PW + LW;

	// configuration
	logic [3:0]  act_q;
	logic [15:0] thr_q;
	logic [2:0]  ticks_q;
	logic [15:0] smin_q;
	logic [15:0] smax_q;
	logic [15:0] rgap_q;

	// transaction capture
	logic [ctsd_pkg::KIND_W-1:0]  kind_q;
	logic [ctsd_pkg::PAD_W-1:0]   pad_q;
	logic [ctsd_pkg::LEVEL_W-1:0] level_q;
	logic [ctsd_pkg::NOW_W-1:0]   now_q;

	// pad state
	logic [15:0] filt_q  [MAX_PADS];
	logic [15:0] base_q  [MAX_PADS];
	logic [3:0]  pcnt_q  [MAX_PADS];
	logic [31:0] stamp_q [MAX_PADS];
	logic [LW-1:0] sptr_q [MAX_PADS];
	logic [LW-1:0] bptr_q [MAX_PADS];
	logic [LW-1:0] uptr_q [MAX_PADS];
	logic [PHW-1:0] phase_q;

	// sequencing
	logic [PW-1:0] wpad_q;
	logic [1:0]    sel_q;
	logic [15:0]   val_q;
	logic [LW-1:0] cnt_q;
	logic          rd_s1;
	logic [AW-1:0] clr_q;
	logic [31:0]   prev_q;
	logic          fail_q;
	logic [1:0]    dir_q;

	// result staging and output register
	logic [16:0] res_delta_q;
	logic [1:0]  res_pev_q;
	logic [1:0]  res_sev_q;
	logic        m_tvalid_q;
	logic [16:0] delta_q;
	logic [1:0]  pev_q;
	logic [1:0]  sev_q;

	logic [NW-1:0] npads;
	logic [PW-1:0] pidx;
	logic [LW-1:0] ptr_cur, ptr_nxt, lenm1, mid;
	logic [15:0]   wval, med, rdata;
	logic          ram_we;
	logic [AW-1:0] waddr, raddr;
	logic [15:0]   wdata;

	logic [16:0] diff;
	logic        up, was, is_p, touch, release_p, restamp;
	logic [4:0]  c5, nx5, top5;
	logic [31:0] cur, dstep, mag;
	logic [1:0]  here;
	logic        fail_n;

	always_comb begin
		if (act_q == 4'd0) begin
			npads = NW'(1);
		end else if (int'(act_q) > MAX_PADS) begin
			npads = NW'(MAX_PADS);
		end else begin
			npads = NW'(act_q);
		end
	end

	assign pidx = PW'(pad_q);

	always_comb begin
		unique case (sel_q)
			ctsd_pkg::WIN_SAMPLE: begin
				ptr_cur = sptr_q[wpad_q];
				lenm1   = LW'(SAMPLE_DEPTH - 1);
				mid     = LW'(SAMPLE_DEPTH / 2);
			end
			ctsd_pkg::WIN_BASE: begin
				ptr_cur = bptr_q[wpad_q];
				lenm1   = LW'(BASE_DEPTH - 1);
				mid     = LW'(BASE_DEPTH / 2);
			end
			default: begin
				ptr_cur = uptr_q[wpad_q];
				lenm1   = LW'(SUPER_DEPTH - 1);
				mid     = LW'(SUPER_DEPTH / 2);
			end
		endcase
	end

	assign ptr_nxt = (ptr_cur == lenm1) ? '0 : ptr_cur + 1'b1;
	assign wval    = (sel_q == ctsd_pkg::WIN_BASE) ? filt_q[wpad_q] : val_q;

	assign ram_we = cmd.clr | cmd.wr;
	assign waddr  = cmd.clr ? clr_q : {sel_q, wpad_q, ptr_cur};
	assign wdata  = cmd.clr ? 16'd0 : wval;
	assign raddr  = {sel_q, wpad_q, cnt_q};

	ctsd_ram #(
		.WIDTH(16),
		.DEPTH(2 ** AW)
	) u_win_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	ctsd_median #(
		.DEPTH(MAXD),
		.LW   (LW),
		.CW   (CW)
	) u_median (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (cmd.wr),
		.insert(rd_s1),
		.din   (rdata),
		.mid   (mid),
		.med   (med)
	);

	// press counter step
	always_comb begin
		diff = {1'b0, filt_q[wpad_q]} - {1'b0, base_q[wpad_q]};
		up   = $signed({diff[16], diff}) > $signed({2'b00, thr_q});
		c5   = {1'b0, pcnt_q[wpad_q]};
		top5 = {1'b0, ticks_q, 1'b0};
		if (up) begin
			nx5 = c5 + 5'd1;
		end else if (c5 == 5'd0) begin
			nx5 = 5'd0;
		end else begin
			nx5 = c5 - 5'd1;
		end
		if (nx5 > top5) begin
			nx5 = top5;
		end
		was       = c5 >= {2'b00, ticks_q};
		is_p      = nx5 >= {2'b00, ticks_q};
		touch     = is_p && !was;
		release_p = was && !is_p;
		restamp   = (now_q - stamp_q[wpad_q]) > {16'd0, rgap_q};
	end

	// one adjacent pair of the swipe walk
	always_comb begin
		cur    = stamp_q[wpad_q];
		dstep  = cur - prev_q;
		here   = dstep[31] ? ctsd_pkg::SEV_NEG : ctsd_pkg::SEV_POS;
		mag    = dstep[31] ? (32'd0 - dstep) : dstep;
		fail_n = (cur == 32'd0);
		if (wpad_q != '0) begin
			if ((dir_q != ctsd_pkg::SEV_NONE) && (dir_q != here)) begin
				fail_n = 1'b1;
			end
			if ((mag < {16'd0, smin_q}) || (mag > {16'd0, smax_q})) begin
				fail_n = 1'b1;
			end
		end
	end

	always_comb begin
		sts.clr_last   = &clr_q;
		sts.kind       = kind_q;
		sts.pad_ok     = int'(pad_q) < int'(npads);
		sts.rd_last    = cnt_q == lenm1;
		sts.sel        = sel_q;
		sts.phase_zero = phase_q == '0;
		sts.pad_last   = wpad_q == PW'(npads - 1'b1);
		sts.swipe_go   = touch && (int'(npads) >= 3);
		sts.out_free   = !m_tvalid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= ctsd_pkg::RST_ACTIVE;
			thr_q   <= ctsd_pkg::RST_THRESH;
			ticks_q <= ctsd_pkg::RST_TICKS;
			smin_q  <= ctsd_pkg::RST_STEPMIN;
			smax_q  <= ctsd_pkg::RST_STEPMAX;
			rgap_q  <= ctsd_pkg::RST_RESTART;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ctsd_pkg::CFG_ACTIVE:  act_q   <= cfg_data[3:0];
				ctsd_pkg::CFG_THRESH:  thr_q   <= cfg_data;
				ctsd_pkg::CFG_TICKS:   ticks_q <= cfg_data[2:0];
				ctsd_pkg::CFG_STEPMIN: smin_q  <= cfg_data;
				ctsd_pkg::CFG_STEPMAX: smax_q  <= cfg_data;
				ctsd_pkg::CFG_RESTART: rgap_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			pad_q   <= pad;
			level_q <= level;
			now_q   <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			rd_s1   <= 1'b0;
			cnt_q   <= '0;
			wpad_q  <= '0;
			sel_q   <= ctsd_pkg::WIN_SAMPLE;
			phase_q <= '0;
			fail_q  <= 1'b0;
			dir_q   <= ctsd_pkg::SEV_NONE;
			for (int j = 0; j < MAX_PADS; j++) begin
				sptr_q[j] <= '0;
				bptr_q[j] <= '0;
				uptr_q[j] <= '0;
			end
		end else begin
			rd_s1 <= cmd.rd;
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.start_sample) begin
				wpad_q <= pidx;
				sel_q  <= ctsd_pkg::WIN_SAMPLE;
			end
			if (cmd.start_tick) begin
				wpad_q <= '0;
				sel_q  <= ctsd_pkg::WIN_BASE;
				if (int'(phase_q) + 1 >= BASE_DEPTH) begin
					phase_q <= '0;
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
			if (cmd.wr) begin
				cnt_q <= '0;
				unique case (sel_q)
					ctsd_pkg::WIN_SAMPLE: sptr_q[wpad_q] <= ptr_nxt;
					ctsd_pkg::WIN_BASE:   bptr_q[wpad_q] <= ptr_nxt;
					default:              uptr_q[wpad_q] <= ptr_nxt;
				endcase
			end
			if (cmd.rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.res && (sel_q == ctsd_pkg::WIN_BASE) && (phase_q == '0)) begin
				sel_q <= ctsd_pkg::WIN_SUPER;
			end
			if (cmd.next_pad) begin
				wpad_q <= wpad_q + 1'b1;
				sel_q  <= ctsd_pkg::WIN_BASE;
			end
			if (cmd.eval) begin
				wpad_q <= '0;
				fail_q <= 1'b0;
				dir_q  <= ctsd_pkg::SEV_NONE;
			end
			if (cmd.sw_step) begin
				wpad_q <= wpad_q + 1'b1;
				fail_q <= fail_q | fail_n;
				if (wpad_q != '0) begin
					dir_q <= here;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_sample) begin
			val_q <= level_q;
		end
		if (cmd.res && (sel_q == ctsd_pkg::WIN_BASE)) begin
			val_q <= med;
		end
		if (cmd.sw_step) begin
			prev_q <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_PADS; j++) begin
				filt_q[j]  <= '0;
				base_q[j]  <= '0;
				pcnt_q[j]  <= '0;
				stamp_q[j] <= '0;
			end
		end else begin
			if (cmd.calib) begin
				filt_q[pidx] <= level_q;
			end
			if (cmd.res && (sel_q == ctsd_pkg::WIN_SAMPLE)) begin
				filt_q[wpad_q] <= med;
			end
			if (cmd.res && (sel_q == ctsd_pkg::WIN_SUPER)) begin
				base_q[wpad_q] <= med;
			end
			if (cmd.eval) begin
				pcnt_q[wpad_q] <= nx5[3:0];
				if (touch && restamp) begin
					stamp_q[wpad_q] <= now_q;
				end
			end
			if (cmd.sw_end && !fail_q) begin
				for (int j = 0; j < MAX_PADS; j++) begin
					if (j < int'(npads)) begin
						stamp_q[j] <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			res_delta_q <= diff;
			res_sev_q   <= ctsd_pkg::SEV_NONE;
			if (touch) begin
				res_pev_q <= ctsd_pkg::PEV_TOUCH;
			end else if (release_p) begin
				res_pev_q <= ctsd_pkg::PEV_RELEASE;
			end else begin
				res_pev_q <= ctsd_pkg::PEV_NONE;
			end
		end
		if (cmd.sw_end && !fail_q) begin
			res_sev_q <= dir_q;
		end
		if (cmd.out) begin
			delta_q <= res_delta_q;
			pev_q   <= res_pev_q;
			sev_q   <= res_sev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid    = m_tvalid_q;
	assign delta       = delta_q;
	assign pad_event   = pev_q;
	assign swipe_event = sev_q;

endmodule

>>> design/ctsd_ctrl.sv
module ctsd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  ctsd_pkg::sts_t sts,
	output ctsd_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		ST_CLEAR = 11'b000_0000_0001,
		ST_IDLE  = 11'b000_0000_0010,
		ST_DISP  = 11'b000_0000_0100,
		ST_WR    = 11'b000_0000_1000,
		ST_RD    = 11'b000_0001_0000,
		ST_END   = 11'b000_0010_0000,
		ST_RES   = 11'b000_0100_0000,
		ST_EVAL  = 11'b000_1000_0000,
		ST_SWRD  = 11'b001_0000_0000,
		ST_SWEND = 11'b010_0000_0000,
		ST_OUT   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.load = s_tvalid && s_tready;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				priority if (sts.kind == ctsd_pkg::KIND_SAMPLE && sts.pad_ok) begin
					cmd.start_sample = 1'b1;
					state_d          = ST_WR;
				end else if (sts.kind == ctsd_pkg::KIND_TICK) begin
					cmd.start_tick = 1'b1;
					state_d        = ST_WR;
				end else if (sts.kind == ctsd_pkg::KIND_CAL && sts.pad_ok) begin
					cmd.calib = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WR: begin
				cmd.wr  = 1'b1;
				state_d = ST_RD;
			end
			ST_RD: begin
				cmd.rd = 1'b1;
				if (sts.rd_last) begin
					state_d = ST_END;
				end
			end
			ST_END: begin
				state_d = ST_RES;
			end
			ST_RES: begin
				cmd.res = 1'b1;
				priority if (sts.sel == ctsd_pkg::WIN_SAMPLE) begin
					state_d = ST_EVAL;
				end else if (sts.sel == ctsd_pkg::WIN_BASE && sts.phase_zero) begin
					state_d = ST_WR;
				end else if (sts.pad_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.next_pad = 1'b1;
					state_d      = ST_WR;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.swipe_go ? ST_SWRD : ST_OUT;
			end
			ST_SWRD: begin
				cmd.sw_step = 1'b1;
				if (sts.pad_last) begin
					state_d = ST_SWEND;
				end
			end
			ST_SWEND: begin
				cmd.sw_end = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/capacitive_touch_swipe_detector_top.sv
// Sample transaction: one result, plus a swipe walk over the active pads on a touch
// with three or more pads; one transaction at a time.
// Baseline tick: a base window update per active pad, plus a super window update per pad
// on every BASE_DEPTH-th tick; calibration and dropped transactions return straight to idle.
// Reset: async active low; a clearing pass over all 2**(2+clog2(MAX_PADS)+
// clog2(max depth)) window RAM words (1024 by default) precedes the first transaction.
module capacitive_touch_swipe_detector_top #(
	parameter int MAX_PADS     = 8,
	parameter int SAMPLE_DEPTH = 7,
	parameter int BASE_DEPTH   = 20,
	parameter int SUPER_DEPTH  = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // pad[2:0], level[18:3], now_ms[50:19]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // delta[16:0]
	output logic [3:0]  m_tuser,   // pad_event[1:0], swipe_event[3:2]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	ctsd_pkg::cmd_t cmd;
	ctsd_pkg::sts_t sts;
	logic [16:0]    delta;
	logic [1:0]     pad_event;
	logic [1:0]     swipe_event;

	assign cfg_ready = 1'b1;

	ctsd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ctsd_datapath #(
		.MAX_PADS    (MAX_PADS),
		.SAMPLE_DEPTH(SAMPLE_DEPTH),
		.BASE_DEPTH  (BASE_DEPTH),
		.SUPER_DEPTH (SUPER_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.kind       (s_tuser),
		.pad        (s_tdata[2:0]),
		.level      (s_tdata[18:3]),
		.now_ms     (s_tdata[50:19]),
		.cmd        (cmd),
		.sts        (sts),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.delta      (delta),
		.pad_event  (pad_event),
		.swipe_event(swipe_event)
	);

	assign m_tdata = {7'd0, delta};
	assign m_tuser = {swipe_event, pad_event};

endmodule

>>> design/ctsd_checker.sv
`include "capacitive_touch_swipe_detector_top_assert.svh"

module ctsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [3:0]  m_tuser
);

	`CTSD_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "accepted while busy")
	`CTSD_ASSERT_IMP(a_pev_code, m_tvalid, m_tuser[1:0] <= ctsd_pkg::PEV_RELEASE, "bad pad event")
	`CTSD_ASSERT_IMP(a_swipe_on_touch, m_tvalid && (m_tuser[3:2] != ctsd_pkg::SEV_NONE), m_tuser[1:0] == ctsd_pkg::PEV_TOUCH, "swipe w/o touch")
	`CTSD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result dropped")

endmodule

bind capacitive_touch_swipe_detector_top ctsd_checker u_ctsd_checker (.*);
